// ===== rtl/bdphl_pkg.sv =====
`timescale 1ns / 1ps

package bdphl_pkg;

    localparam int TIME_WIDTH_DEF = 32;
    localparam int TIME_FIELD_W   = 32;
    localparam int CFG_DATA_W     = 32;
    localparam int CFG_IDX_W      = 2;

    localparam logic [CFG_DATA_W-1:0] BOUNCE_RESET = 32'd5;
    localparam logic [CFG_DATA_W-1:0] HOLD_RESET   = 32'd1000;

    localparam logic [CFG_IDX_W-1:0] CFG_BOUNCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD   = 2'd1;

    typedef enum logic [3:0] {
        PH_IDLE          = 4'd0,
        PH_WAIT_LOW      = 4'd1,
        PH_START         = 4'd2,
        PH_QUALIFY       = 4'd3,
        PH_PRESSED       = 4'd4,
        PH_REPORT_PRESS  = 4'd5,
        PH_REPORT_HOLD   = 4'd6,
        PH_WAIT_RELEASE  = 4'd7,
        PH_RETURN        = 4'd8
    } t_phase;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_PRESS = 2'd1,
        EV_HOLD  = 2'd2
    } t_event;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] bounce_time;
        logic [CFG_DATA_W-1:0] hold_time;
    } t_cfg;

endpackage

// ===== rtl/bdphl_ctrl.sv =====
`timescale 1ns / 1ps

module bdphl_ctrl #(
    parameter int TIME_WIDTH = bdphl_pkg::TIME_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_step,
    input  logic                                i_level,
    input  logic [bdphl_pkg::TIME_FIELD_W-1:0]  i_now_ms,
    input  bdphl_pkg::t_cfg                     i_cfg,
    output bdphl_pkg::t_event                   o_event,
    output logic                                o_indicator
);

    bdphl_pkg::t_phase     r_phase, n_phase;
    logic [TIME_WIDTH-1:0] r_press_start, n_press_start;
    logic                  r_indicator, n_indicator;

    logic [TIME_WIDTH-1:0] w_now;
    logic [TIME_WIDTH-1:0] w_elapsed;
    logic                  w_bounce_done;
    logic                  w_hold_done;

    assign w_now         = TIME_WIDTH'(i_now_ms);
    assign w_elapsed     = w_now - r_press_start;
    assign w_bounce_done = w_elapsed > TIME_WIDTH'(i_cfg.bounce_time);
    assign w_hold_done   = w_elapsed > TIME_WIDTH'(i_cfg.hold_time);

    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            bdphl_pkg::PH_IDLE: begin
                n_phase = bdphl_pkg::PH_WAIT_LOW;
            end
            bdphl_pkg::PH_WAIT_LOW: begin
                if (!i_level) begin
                    n_phase = bdphl_pkg::PH_START;
                end
            end
            bdphl_pkg::PH_START: begin
                n_phase = bdphl_pkg::PH_QUALIFY;
            end
            bdphl_pkg::PH_QUALIFY: begin
                // release aborts even when the bounce delay has just passed
                if (i_level) begin
                    n_phase = bdphl_pkg::PH_IDLE;
                end else if (w_bounce_done) begin
                    n_phase = bdphl_pkg::PH_PRESSED;
                end
            end
            bdphl_pkg::PH_PRESSED: begin
                // hold wins over a release in the same poll
                if (w_hold_done) begin
                    n_phase = bdphl_pkg::PH_REPORT_HOLD;
                end else if (i_level) begin
                    n_phase = bdphl_pkg::PH_REPORT_PRESS;
                end
            end
            bdphl_pkg::PH_REPORT_PRESS: begin
                n_phase = bdphl_pkg::PH_IDLE;
            end
            bdphl_pkg::PH_REPORT_HOLD: begin
                n_phase = bdphl_pkg::PH_WAIT_RELEASE;
            end
            bdphl_pkg::PH_WAIT_RELEASE: begin
                if (i_level) begin
                    n_phase = bdphl_pkg::PH_RETURN;
                end
            end
            default: begin
                n_phase = bdphl_pkg::PH_IDLE;
            end
        endcase
    end

    always_comb begin
        n_press_start = r_press_start;
        n_indicator   = r_indicator;
        o_event       = bdphl_pkg::EV_NONE;
        case (r_phase)
            bdphl_pkg::PH_IDLE: begin
                n_indicator = 1'b0;
            end
            bdphl_pkg::PH_START: begin
                n_indicator   = 1'b1;
                n_press_start = w_now;
            end
            bdphl_pkg::PH_QUALIFY,
            bdphl_pkg::PH_PRESSED,
            bdphl_pkg::PH_WAIT_RELEASE: begin
                n_indicator = 1'b1;
            end
            bdphl_pkg::PH_REPORT_PRESS: begin
                o_event = bdphl_pkg::EV_PRESS;
            end
            bdphl_pkg::PH_REPORT_HOLD: begin
                o_event = bdphl_pkg::EV_HOLD;
            end
            default: begin
                n_indicator = r_indicator;
            end
        endcase
    end

    assign o_indicator = n_indicator;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= bdphl_pkg::PH_IDLE;
            r_press_start <= '0;
            r_indicator   <= 1'b0;
        end else if (i_step) begin
            r_phase       <= n_phase;
            r_press_start <= n_press_start;
            r_indicator   <= n_indicator;
        end
    end

endmodule

// ===== rtl/button_debounce_press_hold_led.sv =====
`timescale 1ns / 1ps

// Switch debounce with press and hold detection.
// Input channel (i_valid / o_stall): one poll per item, carrying the
// active-low switch level and the free-running millisecond timestamp.
// Output channel (o_valid / i_stall): exactly one result per poll, the
// event code (none, press, hold) and the indicator drive after that poll.
// Configuration channel (i_cfg_valid / o_cfg_ready, always ready): index 0
// sets the bounce delay, index 1 the hold delay; other indexes are ignored.
// Write it only while no poll is in flight.
// An accepted poll is captured in the input register; the state update and
// the result register then take it in one pass once the output can advance.
// Throughput is one poll per cycle while the receiver does not stall; the
// state update is one subtract and two compares on TIME_WIDTH bits.
// When the receiver stalls, the result register holds and the input register
// fills; the input side stalls only when both are full.
// Synchronous reset returns the machine to idle, clears the start time and
// the indicator, empties both registers and loads the default delays.
module button_debounce_press_hold_led #(
    parameter int TIME_WIDTH = bdphl_pkg::TIME_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_level,
    input  logic [bdphl_pkg::TIME_FIELD_W-1:0]  i_now_ms,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [1:0]                          o_event_res,
    output logic                                o_indicator,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [bdphl_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [bdphl_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    logic                               r_in_valid;
    logic                               r_in_level;
    logic [bdphl_pkg::TIME_FIELD_W-1:0] r_in_now;
    logic                               r_out_valid;
    bdphl_pkg::t_event                  r_out_event;
    logic                               r_out_indicator;
    bdphl_pkg::t_cfg                    r_cfg;

    logic                               w_advance;
    logic                               w_step;
    bdphl_pkg::t_event                  w_event;
    logic                               w_indicator;

    assign w_advance   = !r_out_valid || !i_stall;
    assign w_step      = w_advance && r_in_valid;
    assign o_stall     = r_in_valid && !w_advance;
    assign o_cfg_ready = 1'b1;

    assign o_valid     = r_out_valid;
    assign o_event_res = r_out_event;
    assign o_indicator = r_out_indicator;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bounce_time <= bdphl_pkg::BOUNCE_RESET;
            r_cfg.hold_time   <= bdphl_pkg::HOLD_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                bdphl_pkg::CFG_BOUNCE: r_cfg.bounce_time <= i_cfg_data;
                bdphl_pkg::CFG_HOLD:   r_cfg.hold_time   <= i_cfg_data;
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    // input register: refill whenever its item moves on or it is empty
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_in_level <= i_level;
            r_in_now   <= i_now_ms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out_event     <= w_event;
            r_out_indicator <= w_indicator;
        end
    end

    bdphl_ctrl #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_step),
        .i_level     (r_in_level),
        .i_now_ms    (r_in_now),
        .i_cfg       (r_cfg),
        .o_event     (w_event),
        .o_indicator (w_indicator)
    );

endmodule

// ===== tb/press_event_checker.sv =====
`timescale 1ns / 1ps

module press_event_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_poll_valid,
    input  logic                               i_poll_stall,
    input  logic                               i_level,
    input  logic [bdphl_pkg::TIME_FIELD_W-1:0] i_now_ms,
    input  logic                               i_res_valid,
    input  logic                               i_res_stall,
    input  logic [1:0]                         i_event_res,
    input  logic                               i_indicator,
    input  logic                               i_cfg_valid,
    input  logic                               i_cfg_ready,
    input  logic [bdphl_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [bdphl_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output int                                 o_fail_count,
    output int                                 o_pending
);

    localparam int TW = bdphl_pkg::TIME_WIDTH_DEF;
    localparam logic [31:0] TIME_MASK = (TW >= 32) ? 32'hFFFF_FFFF : ((32'd1 << TW) - 32'd1);

    typedef struct packed {
        bdphl_pkg::t_event ev;
        logic              ind;
    } t_poll_result;

    t_poll_result expected_results[$];

    bdphl_pkg::t_phase fsm_phase;
    logic [31:0]       press_start_ms;
    logic              led_level;
    logic [31:0]       bounce_ms;
    logic [31:0]       hold_ms;

    int mismatches;
    int results_seen;
    int waiting;

    assign o_fail_count = mismatches;
    assign o_pending    = waiting;

    // One poll through the debounce machine; updates the shadow state.
    task automatic step_debounce(input logic lvl, input logic [31:0] now_t,
                                 output t_poll_result res);
        logic [31:0]       elapsed;
        bdphl_pkg::t_event ev;
        ev      = bdphl_pkg::EV_NONE;
        elapsed = ((now_t & TIME_MASK) - press_start_ms) & TIME_MASK;
        case (fsm_phase)
            bdphl_pkg::PH_IDLE: begin
                led_level = 1'b0;
                fsm_phase = bdphl_pkg::PH_WAIT_LOW;
            end
            bdphl_pkg::PH_WAIT_LOW: begin
                if (!lvl) fsm_phase = bdphl_pkg::PH_START;
            end
            bdphl_pkg::PH_START: begin
                led_level      = 1'b1;
                press_start_ms = now_t & TIME_MASK;
                fsm_phase      = bdphl_pkg::PH_QUALIFY;
            end
            bdphl_pkg::PH_QUALIFY: begin
                led_level = 1'b1;
                if (elapsed > (bounce_ms & TIME_MASK)) fsm_phase = bdphl_pkg::PH_PRESSED;
                // release wins over qualification
                if (lvl) fsm_phase = bdphl_pkg::PH_IDLE;
            end
            bdphl_pkg::PH_PRESSED: begin
                led_level = 1'b1;
                if (lvl) fsm_phase = bdphl_pkg::PH_REPORT_PRESS;
                // hold wins over release
                if (elapsed > (hold_ms & TIME_MASK)) fsm_phase = bdphl_pkg::PH_REPORT_HOLD;
            end
            bdphl_pkg::PH_REPORT_PRESS: begin
                ev        = bdphl_pkg::EV_PRESS;
                fsm_phase = bdphl_pkg::PH_IDLE;
            end
            bdphl_pkg::PH_REPORT_HOLD: begin
                ev        = bdphl_pkg::EV_HOLD;
                fsm_phase = bdphl_pkg::PH_WAIT_RELEASE;
            end
            bdphl_pkg::PH_WAIT_RELEASE: begin
                led_level = 1'b1;
                if (lvl) fsm_phase = bdphl_pkg::PH_RETURN;
            end
            default: begin
                fsm_phase = bdphl_pkg::PH_IDLE;
            end
        endcase
        res.ev  = ev;
        res.ind = led_level;
    endtask

    always @(posedge i_clk) begin
        t_poll_result want;
        t_poll_result got;
        if (!i_rst_n) begin
            fsm_phase      = bdphl_pkg::PH_IDLE;
            press_start_ms = '0;
            led_level      = 1'b0;
            bounce_ms      = bdphl_pkg::BOUNCE_RESET;
            hold_ms        = bdphl_pkg::HOLD_RESET;
            expected_results.delete();
            waiting      = 0;
            mismatches   = 0;
            results_seen = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    bdphl_pkg::CFG_BOUNCE: bounce_ms = i_cfg_data;
                    bdphl_pkg::CFG_HOLD:   hold_ms   = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_poll_valid && !i_poll_stall) begin
                step_debounce(i_level, i_now_ms, got);
                expected_results.push_back(got);
            end
            if (i_res_valid && !i_res_stall) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d: unexpected item, event %0d indicator %0b",
                                 results_seen, i_event_res, i_indicator);
                end else begin
                    want = expected_results.pop_front();
                    if (i_event_res !== want.ev || i_indicator !== want.ind) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result %0d: exp %0d/%0b got %0d/%0b",
                                     results_seen, want.ev, want.ind,
                                     i_event_res, i_indicator);
                    end
                end
            end
            waiting = expected_results.size();
        end
    end

endmodule

// ===== tb/button_debounce_press_hold_led_tb.sv =====
`timescale 1ns / 1ps

module button_debounce_press_hold_led_tb;

    localparam int CYCLE_LIMIT    = 600000;
    localparam int SQUEEZE_CYCLES = 300;
    localparam logic [bdphl_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    logic                               i_clk       = 1'b0;
    logic                               i_rst_n     = 1'b0;
    logic                               i_valid     = 1'b0;
    logic                               i_level     = 1'b1;
    logic [bdphl_pkg::TIME_FIELD_W-1:0] i_now_ms    = '0;
    logic                               i_stall     = 1'b0;
    logic                               i_cfg_valid = 1'b0;
    logic [bdphl_pkg::CFG_IDX_W-1:0]    i_cfg_index = '0;
    logic [bdphl_pkg::CFG_DATA_W-1:0]   i_cfg_data  = '0;
    logic                               o_stall;
    logic                               o_valid;
    logic [1:0]                         o_event_res;
    logic                               o_indicator;
    logic                               o_cfg_ready;

    int          fail_count;
    int          pending_count;
    int          cycle_count = 0;
    int          polls_sent  = 0;
    int          quiet_left  = 0;
    logic        squeeze_req = 1'b0;
    logic [31:0] wall_ms     = '0;

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    button_debounce_press_hold_led DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_level     (i_level),
        .i_now_ms    (i_now_ms),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_event_res (o_event_res),
        .o_indicator (o_indicator),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    press_event_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_poll_valid (i_valid),
        .i_poll_stall (o_stall),
        .i_level      (i_level),
        .i_now_ms     (i_now_ms),
        .i_res_valid  (o_valid),
        .i_res_stall  (i_stall),
        .i_event_res  (o_event_res),
        .i_indicator  (o_indicator),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    // Mostly short gaps, a few long ones, and now and then a run with none.
    function automatic int next_gap();
        int r;
        if (quiet_left > 0) begin
            quiet_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4) begin
            quiet_left = $urandom_range(20, 60);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_poll(input logic lvl, input logic [31:0] t);
        int gap;
        gap = next_gap();
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid  = 1'b1;
        i_level  = lvl;
        i_now_ms = t;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        polls_sent++;
        @(negedge i_clk);
    endtask

    // Advance the millisecond clock, with an occasional jump, then poll.
    task automatic poll_at(input logic lvl, input logic [31:0] step_max);
        if ($urandom_range(0, 49) == 0) wall_ms = $urandom();
        else wall_ms = wall_ms + $urandom_range(0, step_max);
        send_poll(lvl, wall_ms);
    endtask

    task automatic write_reg(input logic [bdphl_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bdphl_pkg::CFG_DATA_W-1:0] val);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic settle();
        i_valid = 1'b0;
        while (pending_count != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic run_setting(input logic [31:0] bounce, input logic [31:0] hold,
                               input logic [31:0] step_max, input int n_polls,
                               input logic squeeze, input logic wrap_start);
        int   stop_at;
        int   r;
        int   len;
        int   k;
        logic chatter;
        settle();
        write_reg(bdphl_pkg::CFG_BOUNCE, bounce);
        write_reg(bdphl_pkg::CFG_HOLD, hold);
        i_cfg_valid = 1'b0;
        if (wrap_start) wall_ms = 32'hFFFF_FFFF - $urandom_range(0, 3000);
        if (squeeze) squeeze_req = 1'b1;
        stop_at = polls_sent + n_polls;
        while (polls_sent < stop_at) begin
            r = $urandom_range(0, 99);
            if (r < 75) begin
                // press episode: released, held low for a while, released again
                chatter = ($urandom_range(0, 9) < 3);
                repeat ($urandom_range(1, 4)) poll_at(1'b1, step_max);
                r = $urandom_range(0, 99);
                if (r < 50) len = $urandom_range(1, 8);
                else if (r < 85) len = $urandom_range(9, 40);
                else len = $urandom_range(41, 120);
                for (k = 0; k < len; k++)
                    poll_at(chatter && ($urandom_range(0, 9) == 0), step_max);
                repeat ($urandom_range(1, 6)) poll_at(1'b1, step_max);
            end else begin
                repeat ($urandom_range(1, 10)) poll_at(1'($urandom_range(0, 1)), step_max);
            end
        end
    endtask

    initial begin
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset delays: bounce 5, hold 1000; timestamps wrap through zero
        send_poll(1'b1, 32'h0000_0000);
        send_poll(1'b1, 32'hFFFF_FFFF);
        send_poll(1'b0, 32'hFFFF_FFF0);
        send_poll(1'b0, 32'hFFFF_FFFE);
        send_poll(1'b0, 32'hFFFF_FFFF);
        // bounce passed and released in the same poll: abort
        send_poll(1'b1, 32'h0000_0005);
        send_poll(1'b0, 32'h0000_0006);
        send_poll(1'b0, 32'h0000_0010);
        send_poll(1'b0, 32'h0000_0064);
        // exactly at the bounce delay: not yet qualified
        send_poll(1'b0, 32'h0000_0069);
        send_poll(1'b0, 32'h0000_006A);
        // release exactly at the hold delay: short press
        send_poll(1'b1, 32'h0000_044C);
        send_poll(1'b1, 32'h0000_044D);
        send_poll(1'b0, 32'h0000_0500);
        send_poll(1'b0, 32'h0000_0600);
        send_poll(1'b0, 32'h0000_07D0);
        send_poll(1'b0, 32'h0000_07DA);
        // hold and release together: hold wins
        send_poll(1'b1, 32'h0000_0BB9);
        send_poll(1'b1, 32'h0000_0BBA);
        send_poll(1'b0, 32'h0000_0BBB);
        send_poll(1'b1, 32'h0000_0BBC);
        send_poll(1'b0, 32'h0000_0BBD);
        send_poll(1'b0, 32'h8000_0000);

        run_setting(32'd5, 32'd1000, 32'd60, 360, 1'b1, 1'b0);
        run_setting(32'd0, 32'd0, 32'd4, 360, 1'b0, 1'b1);
        settle();
        write_reg(CFG_SPARE, $urandom());
        i_cfg_valid = 1'b0;
        run_setting(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h9000_0000, 150, 1'b0, 1'b1);
        run_setting(32'd3, 32'd40, 32'd8, 330, 1'b1, 1'b0);
        run_setting($urandom_range(0, 20), $urandom_range(10, 300), 32'd15, 330,
                    1'b0, 1'b1);
        run_setting(32'h7FFF_FFFF, 32'hFFFF_FFFE, 32'h9000_0000, 270, 1'b0, 1'b0);
        settle();

        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Receiver: random stall runs, plus a long hold-off on request.
    initial begin : stall_gen
        int r;
        int len;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            if (squeeze_req) begin
                squeeze_req = 1'b0;
                i_stall     = 1'b1;
                repeat (SQUEEZE_CYCLES) @(negedge i_clk);
                i_stall = 1'b0;
                @(negedge i_clk);
            end else begin
                r = $urandom_range(0, 99);
                if (r < 20) begin
                    i_stall = 1'b0;
                    repeat ($urandom_range(20, 80)) @(negedge i_clk);
                end else begin
                    len = (r < 88) ? $urandom_range(1, 3) : $urandom_range(8, 50);
                    i_stall = 1'b1;
                    repeat (len) @(negedge i_clk);
                    i_stall = 1'b0;
                    repeat ($urandom_range(1, 6)) @(negedge i_clk);
                end
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("end of test: mismatches");
        $finish;
    end

endmodule
